FILE: rtl/psg_pkg.sv
// Shared types, constants and helpers of the PNG scanline to gray converter.
// Depends on nothing; every other file of the block imports it.
package psg_pkg;

	// default sizes
	localparam int DefMaxRowPixels  = 4096;
	localparam int DefPaletteEntries = 256;
	localparam int QueueDepth        = 4;

	// configuration register indexes
	localparam logic [2:0] REG_PIXEL_KIND       = 3'd0;
	localparam logic [2:0] REG_DEPTH_CODE       = 3'd1;
	localparam logic [2:0] REG_HAS_TRANSPARENCY = 3'd2;
	localparam logic [2:0] REG_TRANSPARENT_KEY  = 3'd3;
	localparam logic [2:0] REG_KEEP_ALPHA       = 3'd4;
	localparam logic [2:0] REG_ROW_WIDTH        = 3'd5;
	localparam logic [2:0] REG_PALETTE_PRESENT  = 3'd6;

	// pixel kinds
	localparam logic [2:0] KIND_GRAY       = 3'd0;
	localparam logic [2:0] KIND_RGB        = 3'd1;
	localparam logic [2:0] KIND_INDEXED    = 3'd2;
	localparam logic [2:0] KIND_GRAY_ALPHA = 3'd3;
	localparam logic [2:0] KIND_RGBA       = 3'd4;

	// item function codes
	localparam logic FUNC_SCANLINE  = 1'b0;
	localparam logic FUNC_PAL_WRITE = 1'b1;

	// fixed output values
	localparam logic [7:0] UNKNOWN_GRAY = 8'd128;
	localparam logic [7:0] OPAQUE       = 8'd255;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic [7:0] pal_index;
		logic [7:0] pal_red;
		logic [7:0] pal_green;
		logic [7:0] pal_blue;
		logic [7:0] pal_alpha;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  gray;
		logic [7:0]  alpha;
		logic [11:0] column;
		logic        row_end;
		logic        run_last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  pixel_kind;
		logic [1:0]  depth_code;
		logic        has_transparency;
		logic [23:0] transparent_key;
		logic        keep_alpha;
		logic [12:0] row_width;
		logic        palette_present;
	} cfg_t;

	// work for the back end
	typedef enum logic [1:0] {
		OP_DIRECT,
		OP_LUMA,
		OP_PALETTE,
		OP_PAL_WRITE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [23:0] color;
		logic [7:0]  alpha;
		logic [7:0]  idx;
		logic [11:0] column;
		logic        row_end;
		logic        run_last;
	} job_t;

	// luma of an rgb triple: (77 r + 150 g + 29 b) >> 8
	function automatic logic [7:0] luma(input logic [23:0] c);
		logic [15:0] sum;
		sum = 16'(c[23:16]) * 16'd77 + 16'(c[15:8]) * 16'd150 + 16'(c[7:0]) * 16'd29;
		return sum[15:8];
	endfunction

	// exact x / 255 for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

FILE: rtl/psg_front.sv
// Front end: accepts items, unpacks samples, gathers multi-byte pixels and
// tracks the column. Emits a job per cycle unless q_full. Uses psg_pkg.
module psg_front #(
	parameter int MAX_ROW_PIXELS = psg_pkg::DefMaxRowPixels
) (
	input  logic             clk,
	input  logic             arst_n,
	input  psg_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  psg_pkg::in_item_t in_item,
	input  logic             q_full,
	output logic             q_push,
	output psg_pkg::job_t    q_job
);
	import psg_pkg::*;

	localparam int CW   = $clog2(MAX_ROW_PIXELS);
	localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;

	in_item_t       item_q;
	logic           busy_q;
	logic [2:0]     sub_q;
	logic [23:0]    partial_q;
	logic [1:0]     phase_q;
	logic [CW-1:0]  column_q;

	logic [CMPW-1:0] rw_ext, eff_w, col_next;
	logic            end_px;
	logic [31:0]     col_ext;
	logic [2:0]      last_sub, s_scaled;
	logic [3:0]      bits, shift;
	logic [7:0]      maxs, smp, expd;
	logic [2:0]      phase_inc;
	logic            gen, last, is_pixel, fire;
	job_t            job;

	// effective row width and end of row
	always_comb begin
		rw_ext = CMPW'(cfg.row_width);
		if (rw_ext == '0)
			eff_w = CMPW'(1);
		else if (rw_ext > CMPW'(MAX_ROW_PIXELS))
			eff_w = CMPW'(MAX_ROW_PIXELS);
		else
			eff_w = rw_ext;
		col_next = CMPW'(column_q) + CMPW'(1);
		end_px   = (col_next >= eff_w);
		col_ext  = 32'(column_q);
	end

	// packed sample extraction, most significant sample first
	always_comb begin
		last_sub = 3'(3'd7 >> cfg.depth_code);
		s_scaled = 3'(sub_q << cfg.depth_code);
		bits     = 4'(4'd1 << cfg.depth_code);
		shift    = 4'd8 - bits - {1'b0, s_scaled};
		case (cfg.depth_code)
			2'd0:    maxs = 8'd1;
			2'd1:    maxs = 8'd3;
			2'd2:    maxs = 8'd15;
			default: maxs = 8'd255;
		endcase
		smp = (item_q.data_byte >> shift) & maxs;
		case (cfg.depth_code)
			2'd0:    expd = smp[0] ? 8'd255 : 8'd0;
			2'd1:    expd = 8'(smp * 8'd85);
			2'd2:    expd = 8'(smp * 8'd17);
			default: expd = smp;
		endcase
	end

	// job for the current item and sample
	always_comb begin
		job          = '0;
		job.column   = col_ext[11:0];
		job.row_end  = end_px;
		job.run_last = 1'b1;
		gen          = 1'b1;
		last         = 1'b1;
		is_pixel     = 1'b1;
		phase_inc    = {1'b0, phase_q} + 3'd1;
		if (item_q.func == FUNC_PAL_WRITE) begin
			job.op    = OP_PAL_WRITE;
			job.idx   = item_q.pal_index;
			job.color = {item_q.pal_red, item_q.pal_green, item_q.pal_blue};
			job.alpha = item_q.pal_alpha;
			is_pixel  = 1'b0;
		end else begin
			unique case (cfg.pixel_kind) inside
				KIND_GRAY, KIND_INDEXED: begin
					last         = (sub_q == last_sub) || end_px;
					job.run_last = last;
					if (cfg.pixel_kind == KIND_GRAY) begin
						job.op    = OP_DIRECT;
						job.color = {16'd0, expd};
						job.alpha = (cfg.has_transparency &&
							smp == cfg.transparent_key[7:0]) ? 8'd0 : OPAQUE;
					end else if (cfg.palette_present) begin
						job.op  = OP_PALETTE;
						job.idx = smp;
					end else begin
						job.op    = OP_DIRECT;
						job.color = {16'd0, expd};
						job.alpha = OPAQUE;
					end
				end
				KIND_RGB: begin
					gen       = (phase_inc >= 3'd3);
					job.op    = OP_LUMA;
					job.color = {partial_q[15:0], item_q.data_byte};
					job.alpha = (cfg.has_transparency &&
						job.color == cfg.transparent_key) ? 8'd0 : OPAQUE;
				end
				KIND_GRAY_ALPHA: begin
					gen       = (phase_inc >= 3'd2);
					job.op    = OP_DIRECT;
					job.color = {16'd0, partial_q[7:0]};
					job.alpha = item_q.data_byte;
				end
				KIND_RGBA: begin
					gen       = (phase_inc >= 3'd4);
					job.op    = OP_LUMA;
					job.color = partial_q;
					job.alpha = item_q.data_byte;
				end
				default: begin
					job.op    = OP_DIRECT;
					job.color = {16'd0, UNKNOWN_GRAY};
					job.alpha = OPAQUE;
				end
			endcase
		end
	end

	// handshake: next item is taken in the cycle the current one finishes
	always_comb begin
		fire     = busy_q && (!gen || !q_full);
		q_push   = fire && gen;
		q_job    = job;
		in_ready = !busy_q || (fire && last);
	end

	// item hold and sample counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sub_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			sub_q  <= '0;
		end else if (fire && last) begin
			busy_q <= 1'b0;
			sub_q  <= '0;
		end else if (fire) begin
			sub_q <= sub_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_q <= in_item;
	end

	// row state: gathered bytes and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			phase_q   <= '0;
			column_q  <= '0;
		end else if (fire && is_pixel) begin
			if (gen)
				column_q <= end_px ? '0 : CW'(col_next);
			if (!gen) begin
				partial_q <= {partial_q[15:0], item_q.data_byte};
				phase_q   <= phase_inc[1:0];
			end else begin
				partial_q <= '0;
				phase_q   <= '0;
			end
		end
	end

endmodule

FILE: rtl/psg_queue.sv
// Short job queue between the front and back ends.
// Uses psg_pkg for the job type and depth.
module psg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  psg_pkg::job_t push_job,
	input  logic          pop,
	output psg_pkg::job_t head_job,
	output logic          full,
	output logic          empty
);
	import psg_pkg::*;

	localparam int AW = $clog2(QueueDepth);

	job_t          slot_q [QueueDepth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	always_comb begin
		full     = (count_q == (AW+1)'(QueueDepth));
		empty    = (count_q == '0);
		head_job = slot_q[rd_ptr_q];
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + (AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (AW+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

endmodule

FILE: rtl/psg_back.sv
// Back end: palette memory, luma, compositing over white and the output register.
// Four stages that advance together. Uses psg_pkg.
module psg_back #(
	parameter int PALETTE_ENTRIES = psg_pkg::DefPaletteEntries
) (
	input  logic              clk,
	input  logic              arst_n,
	input  psg_pkg::cfg_t     cfg,
	input  psg_pkg::job_t     head_job,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output psg_pkg::out_item_t out_item
);
	import psg_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [31:0] pal_mem [PALETTE_ENTRIES];

	logic        en, in_range;
	logic [AW-1:0] addr;

	logic        valid_s1, oob_s1;
	job_t        job_s1;
	logic [31:0] pal_rdata_s1;

	logic        valid_s2;
	logic [7:0]  gray_s2, alpha_s2;
	logic [11:0] column_s2;
	logic        row_end_s2, run_last_s2;

	logic        valid_s3;
	logic [7:0]  gray_s3, alpha_s3;
	logic [15:0] mix_s3;
	logic [11:0] column_s3;
	logic        row_end_s3, run_last_s3;

	logic        out_valid_q;
	out_item_t   out_item_q;

	logic [23:0] pal_color;
	logic [7:0]  gray_c, alpha_c;
	logic [15:0] mix_c;

	// whole pipeline moves when the output register is free
	always_comb begin
		en       = !out_valid_q || out_ready;
		q_pop    = en && !q_empty;
		in_range = ({1'b0, head_job.idx} < 9'(PALETTE_ENTRIES));
		addr     = head_job.idx[AW-1:0];
	end

	// palette memory: write and registered read
	always_ff @(posedge clk) begin
		if (q_pop && head_job.op == OP_PAL_WRITE && in_range)
			pal_mem[addr] <= {head_job.alpha, head_job.color};
		if (en)
			pal_rdata_s1 <= pal_mem[addr];
	end

	// stage 1: job taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= q_pop && head_job.op != OP_PAL_WRITE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1 <= head_job;
			oob_s1 <= !in_range;
		end
	end

	// stage 2 logic: gray and alpha
	always_comb begin
		pal_color = oob_s1 ? 24'd0 : pal_rdata_s1[23:0];
		gray_c    = job_s1.color[7:0];
		alpha_c   = job_s1.alpha;
		unique case (job_s1.op)
			OP_LUMA:    gray_c = luma(job_s1.color);
			OP_PALETTE: begin
				gray_c  = luma(pal_color);
				alpha_c = !cfg.has_transparency ? OPAQUE :
					(oob_s1 ? 8'd0 : pal_rdata_s1[31:24]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_s2     <= gray_c;
			alpha_s2    <= alpha_c;
			column_s2   <= job_s1.column;
			row_end_s2  <= job_s1.row_end;
			run_last_s2 <= job_s1.run_last;
		end
	end

	// stage 3: g*a + 255*(255-a)
	always_comb begin
		mix_c = 16'(gray_s2) * 16'(alpha_s2) + 16'd255 * 16'(OPAQUE - alpha_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mix_s3      <= mix_c;
			gray_s3     <= gray_s2;
			alpha_s3    <= alpha_s2;
			column_s3   <= column_s2;
			row_end_s3  <= row_end_s2;
			run_last_s3 <= run_last_s2;
		end
	end

	// output register: divide by 255 or pass raw gray
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item_q.gray     <= cfg.keep_alpha ? gray_s3 : div255(mix_s3);
			out_item_q.alpha    <= alpha_s3;
			out_item_q.column   <= column_s3;
			out_item_q.row_end  <= row_end_s3;
			out_item_q.run_last <= run_last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: rtl/png_scanline_to_gray_core.sv
// PNG scanline to gray converter: top level with the configuration registers.
// Instantiates psg_front, psg_queue and psg_back; uses psg_pkg.
//
// Takes decoded scanline bytes (or palette writes) on the in channel and gives
// 8-bit gray and alpha per pixel on the out channel, with column, row end and
// a flag on the last pixel caused by each byte. The front end takes one item
// per cycle for 8-bit gray/indexed, unknown kinds, multi-byte kinds and palette
// writes unless a job waits on a full queue; a packed byte is held until all
// its pixels are out (8, 4 or 2 at 1, 2 or 4 bits per sample, fewer when the
// row ends inside the byte), as the unpacker emits one pixel per cycle while
// the queue has room. A four-entry job queue lets the front end keep working
// while the output is stalled. Configuration must be written over the APB
// port only while the block is idle; the block does not enforce this.
// Palette entries must be written before an indexed pixel reads them.
module png_scanline_to_gray_core #(
	parameter int MAX_ROW_PIXELS  = psg_pkg::DefMaxRowPixels,
	parameter int PALETTE_ENTRIES = psg_pkg::DefPaletteEntries
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  psg_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output psg_pkg::out_item_t out_item
);
	import psg_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	logic q_full, q_empty, q_push, q_pop;
	job_t push_job, head_job;

	// register write and read
	always_comb begin
		pready  = 1'b1;
		reg_idx = paddr[4:2];
		wr_en   = psel && penable && pwrite;
		unique case (reg_idx)
			REG_PIXEL_KIND:       prdata = 32'(cfg_q.pixel_kind);
			REG_DEPTH_CODE:       prdata = 32'(cfg_q.depth_code);
			REG_HAS_TRANSPARENCY: prdata = 32'(cfg_q.has_transparency);
			REG_TRANSPARENT_KEY:  prdata = 32'(cfg_q.transparent_key);
			REG_KEEP_ALPHA:       prdata = 32'(cfg_q.keep_alpha);
			REG_ROW_WIDTH:        prdata = 32'(cfg_q.row_width);
			REG_PALETTE_PRESENT:  prdata = 32'(cfg_q.palette_present);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_kind       <= KIND_GRAY;
			cfg_q.depth_code       <= 2'd3;
			cfg_q.has_transparency <= 1'b0;
			cfg_q.transparent_key  <= '0;
			cfg_q.keep_alpha       <= 1'b0;
			cfg_q.row_width        <= 13'd1;
			cfg_q.palette_present  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PIXEL_KIND:       cfg_q.pixel_kind       <= pwdata[2:0];
				REG_DEPTH_CODE:       cfg_q.depth_code       <= pwdata[1:0];
				REG_HAS_TRANSPARENCY: cfg_q.has_transparency <= pwdata[0];
				REG_TRANSPARENT_KEY:  cfg_q.transparent_key  <= pwdata[23:0];
				REG_KEEP_ALPHA:       cfg_q.keep_alpha       <= pwdata[0];
				REG_ROW_WIDTH:        cfg_q.row_width        <= pwdata[12:0];
				REG_PALETTE_PRESENT:  cfg_q.palette_present  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// front end: unpack and classify
	psg_front #(
		.MAX_ROW_PIXELS(MAX_ROW_PIXELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	// job queue
	psg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back end: palette, luma, compositing
	psg_back #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_job  (head_job),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

FILE: test/testbench.sv
// Self-checking testbench for png_scanline_to_gray_core: a directed stimulus table,
// then random register settings and scanline bytes checked against a built-in predictor.
// Depends on psg_pkg and the block's RTL only.
module testbench;
	import psg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;

	png_scanline_to_gray_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predictor state: register copy, palette, row state
	cfg_t        cfg_sh;
	logic [23:0] pal_rgb [256];
	logic [7:0]  pal_opac [256];
	bit          pal_written [256];
	logic [23:0] gather_bytes;
	int          gather_cnt;
	logic [11:0] col_cnt;
	out_item_t   exp_pixels [$];
	out_item_t   cur_px;

	int send_idle_pct;
	int recv_idle_pct;
	int err_cnt;
	int items_sent;
	int pal_writes;
	int pixels_seen;
	int cfg_writes;

	// one row of the directed table: a register write or an item
	typedef struct {
		bit          is_cfg;
		logic [2:0]  reg_idx;
		logic [31:0] value;
		in_item_t    item;
		bit          typed;
		out_item_t   exp_px;
	} step_t;

	step_t dir_rows [$];

	// luma weights 77/150/29 over 256
	function automatic int luma_of(input logic [23:0] c);
		int sum;
		sum = 77 * int'(c[23:16]) + 150 * int'(c[15:8]) + 29 * int'(c[7:0]);
		return (sum >> 8) & 255;
	endfunction

	// queue one pixel at the current column; returns 1 when the row ends
	function automatic bit push_pixel(input int g, input int a);
		int        w;
		int        g_out;
		bit        last_col;
		out_item_t o;
		w = int'(cfg_sh.row_width);
		if (w == 0) w = 1;
		if (w > DefMaxRowPixels) w = DefMaxRowPixels;
		last_col = (int'(col_cnt) + 1 >= w);
		g_out = cfg_sh.keep_alpha ? g : (g * a + 255 * (255 - a)) / 255;
		o.gray = 8'(g_out);
		o.alpha = 8'(a);
		o.column = col_cnt;
		o.row_end = last_col;
		o.run_last = 1'b0;
		exp_pixels.push_back(o);
		col_cnt = last_col ? 12'd0 : col_cnt + 12'd1;
		return last_col;
	endfunction

	// expected pixels of one accepted item
	function automatic void predict_pixels(input in_item_t it);
		int          n0;
		int          bits;
		int          per;
		int          maxs;
		int          smp;
		int          expd;
		int          g;
		int          a;
		int          pix_bytes;
		int          bv;
		logic [23:0] rgb;
		out_item_t   tail;
		n0 = exp_pixels.size();
		bv = int'(it.data_byte);
		if (it.func == FUNC_PAL_WRITE) begin
			pal_rgb[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
			pal_opac[it.pal_index] = it.pal_alpha;
			pal_written[it.pal_index] = 1'b1;
			return;
		end
		case (cfg_sh.pixel_kind) inside
			KIND_GRAY, KIND_INDEXED: begin
				// packed samples, msb first
				bits = 1 << cfg_sh.depth_code;
				per = 8 / bits;
				maxs = (1 << bits) - 1;
				gather_bytes = '0;
				gather_cnt = 0;
				for (int s = 0; s < per; s++) begin
					smp = (bv >> (8 - bits - s * bits)) & maxs;
					expd = smp * 255 / maxs;
					if (cfg_sh.pixel_kind == KIND_GRAY) begin
						g = expd;
						a = (cfg_sh.has_transparency &&
							smp == int'(cfg_sh.transparent_key[7:0])) ? 0 : 255;
					end else if (cfg_sh.palette_present) begin
						g = luma_of(pal_rgb[smp]);
						a = cfg_sh.has_transparency ? int'(pal_opac[smp]) : 255;
					end else begin
						g = expd;
						a = 255;
					end
					if (push_pixel(g, a)) break;
				end
			end
			KIND_RGB, KIND_GRAY_ALPHA, KIND_RGBA: begin
				// gather bytes until the pixel is complete
				pix_bytes = (cfg_sh.pixel_kind == KIND_RGB) ? 3 :
					(cfg_sh.pixel_kind == KIND_GRAY_ALPHA ? 2 : 4);
				if (gather_cnt + 1 >= pix_bytes) begin
					if (cfg_sh.pixel_kind == KIND_GRAY_ALPHA) begin
						g = int'(gather_bytes[7:0]);
						a = bv;
					end else if (cfg_sh.pixel_kind == KIND_RGB) begin
						rgb = {gather_bytes[15:0], it.data_byte};
						g = luma_of(rgb);
						a = (cfg_sh.has_transparency && rgb == cfg_sh.transparent_key) ? 0 : 255;
					end else begin
						g = luma_of(gather_bytes);
						a = bv;
					end
					gather_bytes = '0;
					gather_cnt = 0;
					void'(push_pixel(g, a));
				end else begin
					gather_bytes = {gather_bytes[15:0], it.data_byte};
					gather_cnt = (gather_cnt + 1) & 3;
				end
			end
			default: begin
				gather_bytes = '0;
				gather_cnt = 0;
				void'(push_pixel(int'(UNKNOWN_GRAY), int'(OPAQUE)));
			end
		endcase
		// flag the last pixel of this item
		if (exp_pixels.size() > n0) begin
			tail = exp_pixels[exp_pixels.size() - 1];
			tail.run_last = 1'b1;
			exp_pixels[exp_pixels.size() - 1] = tail;
		end
	endfunction

	function automatic in_item_t make_scan(input logic [7:0] b);
		in_item_t it;
		it.func = FUNC_SCANLINE;
		it.data_byte = b;
		it.pal_index = 8'($urandom);
		it.pal_red = 8'($urandom);
		it.pal_green = 8'($urandom);
		it.pal_blue = 8'($urandom);
		it.pal_alpha = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_pal(input logic [7:0] idx);
		in_item_t it;
		it = make_scan(8'($urandom));
		it.func = FUNC_PAL_WRITE;
		it.pal_index = idx;
		return it;
	endfunction

	// directed table rows
	function automatic out_item_t px(input logic [7:0] g, input logic [7:0] a,
		input logic [11:0] col, input bit row_end, input bit run_last);
		out_item_t o;
		o.gray = g;
		o.alpha = a;
		o.column = col;
		o.row_end = row_end;
		o.run_last = run_last;
		return o;
	endfunction

	function automatic step_t cfg_row(input logic [2:0] reg_idx, input logic [31:0] value);
		step_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.reg_idx = reg_idx;
		r.value = value;
		return r;
	endfunction

	function automatic step_t byte_row(input logic [7:0] b);
		step_t r;
		r = '{default: '0};
		r.item = make_scan(b);
		return r;
	endfunction

	function automatic step_t byte_typed(input logic [7:0] b, input out_item_t o);
		step_t r;
		r = byte_row(b);
		r.typed = 1'b1;
		r.exp_px = o;
		return r;
	endfunction

	function automatic step_t pal_row(input logic [7:0] idx, input logic [23:0] rgb,
		input logic [7:0] a);
		step_t r;
		r = '{default: '0};
		r.item = make_pal(idx);
		{r.item.pal_red, r.item.pal_green, r.item.pal_blue} = rgb;
		r.item.pal_alpha = a;
		return r;
	endfunction

	// register write: setup and access phases, then back to idle
	task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (reg_idx)
			REG_PIXEL_KIND:       cfg_sh.pixel_kind = value[2:0];
			REG_DEPTH_CODE:       cfg_sh.depth_code = value[1:0];
			REG_HAS_TRANSPARENCY: cfg_sh.has_transparency = value[0];
			REG_TRANSPARENT_KEY:  cfg_sh.transparent_key = value[23:0];
			REG_KEEP_ALPHA:       cfg_sh.keep_alpha = value[0];
			REG_ROW_WIDTH:        cfg_sh.row_width = value[12:0];
			REG_PALETTE_PRESENT:  cfg_sh.palette_present = value[0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// present one item, hold it until accepted, then predict
	task automatic send_item(input in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predict_pixels(it);
		items_sent++;
		if (it.func == FUNC_PAL_WRITE) pal_writes++;
	endtask

	// drain: all pixels out, then let in-flight palette writes settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (exp_pixels.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// one random register setting followed by a burst of items
	task automatic random_segment();
		int          kind_pick;
		int          seg_len;
		int          done;
		int          bits;
		int          per;
		int          maxs;
		int          smp;
		int          pix_bytes;
		logic [2:0]  kind;
		logic [23:0] key;
		logic [12:0] width;
		logic [7:0]  b;
		kind_pick = $urandom_range(0, 11);
		case (kind_pick) inside
			0, 1:    kind = KIND_GRAY;
			2, 3:    kind = KIND_RGB;
			4, 5, 6: kind = KIND_INDEXED;
			7, 8:    kind = KIND_GRAY_ALPHA;
			9, 10:   kind = KIND_RGBA;
			default: kind = 3'($urandom_range(5, 7));
		endcase
		wait_idle();
		apb_write(REG_PIXEL_KIND, 32'(kind));
		apb_write(REG_DEPTH_CODE, 32'($urandom_range(0, 3)));
		bits = 1 << cfg_sh.depth_code;
		per = 8 / bits;
		maxs = (1 << bits) - 1;
		case ($urandom_range(0, 3))
			0:       key = 24'hFFFFFF;
			1:       key = 24'($urandom);
			default: key = {16'($urandom), 8'($urandom_range(0, maxs))};
		endcase
		case ($urandom_range(0, 19))
			0:       width = 13'd0;
			1:       width = 13'd4096;
			2:       width = 13'd8191;
			3:       width = 13'd4095;
			default: width = 13'($urandom_range(1, 16));
		endcase
		apb_write(REG_HAS_TRANSPARENCY, 32'($urandom_range(0, 1)));
		apb_write(REG_TRANSPARENT_KEY, 32'(key));
		apb_write(REG_KEEP_ALPHA, 32'($urandom_range(0, 1)));
		apb_write(REG_ROW_WIDTH, 32'(width));
		apb_write(REG_PALETTE_PRESENT, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
		seg_len = $urandom_range(12, 40);
		done = 0;
		while (done < seg_len) begin
			if ($urandom_range(0, 9) == 0) begin
				// stray palette write
				send_item(make_pal(8'($urandom)));
				done++;
			end else if (kind == KIND_RGB || kind == KIND_GRAY_ALPHA || kind == KIND_RGBA) begin
				// whole multi-byte pixel, sometimes exactly the rgb key
				pix_bytes = (kind == KIND_RGB) ? 3 : (kind == KIND_GRAY_ALPHA ? 2 : 4);
				if (kind == KIND_RGB && $urandom_range(0, 3) == 0) begin
					send_item(make_scan(key[23:16]));
					send_item(make_scan(key[15:8]));
					send_item(make_scan(key[7:0]));
				end else begin
					for (int s = 0; s < pix_bytes; s++) send_item(make_scan(8'($urandom)));
				end
				done += pix_bytes;
			end else if (kind == KIND_INDEXED && cfg_sh.palette_present) begin
				// load any entry this byte will read before sending it
				b = 8'($urandom);
				for (int s = 0; s < per; s++) begin
					smp = (int'(b) >> (8 - bits - s * bits)) & maxs;
					if (!pal_written[smp]) send_item(make_pal(8'(smp)));
				end
				send_item(make_scan(b));
				done++;
			end else if (kind == KIND_GRAY && $urandom_range(0, 2) == 0) begin
				// byte made of the key sample
				smp = int'(key[7:0]) & maxs;
				b = '0;
				for (int s = 0; s < per; s++) b = 8'((int'(b) << bits) | smp);
				send_item(make_scan(b));
				done++;
			end else begin
				send_item(make_scan(8'($urandom)));
				done++;
			end
		end
	endtask

	// field by field comparison
	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	// output side: check each accepted pixel, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_ready) begin
				pixels_seen++;
				if (exp_pixels.size() == 0) begin
					$error("pixel at column %0d with no expectation", out_item.column);
					err_cnt++;
				end else begin
					cur_px = exp_pixels.pop_front();
					check_field("gray", 32'(cur_px.gray), 32'(out_item.gray));
					check_field("alpha", 32'(cur_px.alpha), 32'(out_item.alpha));
					check_field("column", 32'(cur_px.column), 32'(out_item.column));
					check_field("row_end", 32'(cur_px.row_end), 32'(out_item.row_end));
					check_field("run_last", 32'(cur_px.run_last), 32'(out_item.run_last));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// stimulus
	initial begin : main_seq
		step_t row;
		int    rand_start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		err_cnt = 0;
		items_sent = 0;
		pal_writes = 0;
		pixels_seen = 0;
		cfg_writes = 0;
		send_idle_pct = 13;
		recv_idle_pct = 73;
		cfg_sh.pixel_kind = KIND_GRAY;
		cfg_sh.depth_code = 2'd3;
		cfg_sh.has_transparency = 1'b0;
		cfg_sh.transparent_key = '0;
		cfg_sh.keep_alpha = 1'b0;
		cfg_sh.row_width = 13'd1;
		cfg_sh.palette_present = 1'b0;
		gather_bytes = '0;
		gather_cnt = 0;
		col_cnt = '0;

		// after reset: 8-bit gray, one pixel per row, over white; then an unknown kind
		dir_rows.push_back(byte_typed(8'h00, px(8'h00, OPAQUE, 12'd0, 1'b1, 1'b1)));
		dir_rows.push_back(byte_typed(8'hFF, px(8'hFF, OPAQUE, 12'd0, 1'b1, 1'b1)));
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 5));
		dir_rows.push_back(byte_typed(8'hA5, px(UNKNOWN_GRAY, OPAQUE, 12'd0, 1'b1, 1'b1)));
		// 1-bit gray keyed on ones, raw alpha, row ends inside the second byte
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 32'(KIND_GRAY)));
		dir_rows.push_back(cfg_row(REG_DEPTH_CODE, 0));
		dir_rows.push_back(cfg_row(REG_HAS_TRANSPARENCY, 1));
		dir_rows.push_back(cfg_row(REG_TRANSPARENT_KEY, 1));
		dir_rows.push_back(cfg_row(REG_KEEP_ALPHA, 1));
		dir_rows.push_back(cfg_row(REG_ROW_WIDTH, 12));
		dir_rows.push_back(byte_row(8'hA5));
		dir_rows.push_back(byte_row(8'hFF));
		// 2-bit gray keyed on the top sample, composited, pad after row end
		dir_rows.push_back(cfg_row(REG_DEPTH_CODE, 1));
		dir_rows.push_back(cfg_row(REG_TRANSPARENT_KEY, 3));
		dir_rows.push_back(cfg_row(REG_KEEP_ALPHA, 0));
		dir_rows.push_back(cfg_row(REG_ROW_WIDTH, 3));
		dir_rows.push_back(byte_row(8'h1B));
		// 4-bit index expanded as gray with no palette
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 32'(KIND_INDEXED)));
		dir_rows.push_back(cfg_row(REG_DEPTH_CODE, 2));
		dir_rows.push_back(byte_row(8'hF0));
		// palette loads, then lookups at 8 and 4 bits
		dir_rows.push_back(pal_row(8'd0, 24'hFFFFFF, 8'h00));
		dir_rows.push_back(pal_row(8'd255, 24'h000000, 8'hFF));
		dir_rows.push_back(pal_row(8'd15, 24'h123456, 8'h80));
		dir_rows.push_back(pal_row(8'd1, 24'h808080, 8'h40));
		dir_rows.push_back(cfg_row(REG_PALETTE_PRESENT, 1));
		dir_rows.push_back(cfg_row(REG_DEPTH_CODE, 3));
		dir_rows.push_back(byte_row(8'h00));
		dir_rows.push_back(byte_row(8'hFF));
		dir_rows.push_back(cfg_row(REG_DEPTH_CODE, 2));
		dir_rows.push_back(byte_row(8'hF1));
		// rgb hitting the key, width above the row limit
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 32'(KIND_RGB)));
		dir_rows.push_back(cfg_row(REG_TRANSPARENT_KEY, 32'h123456));
		dir_rows.push_back(cfg_row(REG_ROW_WIDTH, 8191));
		dir_rows.push_back(byte_row(8'h12));
		dir_rows.push_back(byte_row(8'h34));
		dir_rows.push_back(byte_row(8'h56));
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 32'(KIND_GRAY_ALPHA)));
		dir_rows.push_back(byte_row(8'h80));
		dir_rows.push_back(byte_row(8'h40));
		// rgba left partial, finished as gray+alpha after a kind change
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 32'(KIND_RGBA)));
		dir_rows.push_back(byte_row(8'h10));
		dir_rows.push_back(byte_row(8'h20));
		dir_rows.push_back(byte_row(8'h30));
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 32'(KIND_GRAY_ALPHA)));
		dir_rows.push_back(byte_row(8'h77));
		// zero width acts as one, column already past the end
		dir_rows.push_back(cfg_row(REG_ROW_WIDTH, 0));
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 6));
		dir_rows.push_back(byte_row(8'h5A));
		dir_rows.push_back(cfg_row(REG_PIXEL_KIND, 7));
		dir_rows.push_back(byte_typed(8'h00, px(UNKNOWN_GRAY, OPAQUE, 12'd0, 1'b1, 1'b1)));

		// reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				wait_idle();
				apb_write(row.reg_idx, row.value);
			end else begin
				send_item(row.item);
				if (row.typed && exp_pixels.size() > 0)
					exp_pixels[exp_pixels.size() - 1] = row.exp_px;
			end
		end

		// random part in three idling phases
		rand_start = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (items_sent - rand_start < (phase + 1) * 95) random_segment();
		end

		wait_idle();
		$display("sent %0d items (%0d palette writes) over %0d register writes",
			items_sent, pal_writes, cfg_writes);
		$display("checked %0d pixels, %0d mismatches", pixels_seen, err_cnt);
		if (err_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: png_scanline_to_gray_core.f
rtl/psg_pkg.sv
rtl/psg_front.sv
rtl/psg_queue.sv
rtl/psg_back.sv
rtl/png_scanline_to_gray_core.sv
test/testbench.sv
